### design/ddmcs_pkg.sv
package ddmcs_pkg;

    localparam int unsigned STEP_BITS           = 20;
    localparam int unsigned OUT_CNT_W           = 20;
    localparam int unsigned CONF_SLOPE_UP_STEP  = 0;
    localparam int unsigned CONF_SLOPE_LOW_STEP = 0;
    localparam int unsigned CFG_IDX_W           = 3;
    localparam int unsigned CFG_DATA_W          = 32;

    localparam logic [OUT_CNT_W-1:0] OUT_CNT_MAX = '1;

    typedef logic [STEP_BITS-1:0] t_step;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DRIFT_STEP      = 3'd0,
        REG_POST_DRIFT_STEP = 3'd1,
        REG_START_LEVEL     = 3'd2,
        REG_UPPER_BOUND     = 3'd3,
        REG_BOUND_COLLAPSE  = 3'd4,
        REG_CONF_UPPER      = 3'd5,
        REG_CONF_LOWER      = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] drift_step;
        logic signed [31:0] post_drift_step;
        logic        [30:0] start_level;
        logic        [30:0] upper_bound;
        logic        [30:0] bound_collapse;
        logic signed [31:0] conf_upper;
        logic signed [31:0] conf_lower;
    } t_cfg;

    typedef struct packed {
        logic        [OUT_CNT_W-1:0] decision_steps;
        logic                        choice_upper;
        logic                        correct;
        logic signed [31:0]          decision_evidence;
        logic signed [31:0]          final_evidence;
        logic        [OUT_CNT_W-1:0] confidence_steps;
        logic                        high_confidence;
    } t_result;

    // Clamp a 34-bit signed sum into 32-bit signed range.
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        begin
            if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
                r = v[31:0];
            end else if (v[33]) begin
                r = {1'b1, 31'd0};
            end else begin
                r = {1'b0, {31{1'b1}}};
            end
            return r;
        end
    endfunction

    function automatic logic [30:0] sat_add31(input logic [30:0] a, input logic [30:0] b);
        logic [31:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[31] ? '1 : s[30:0];
        end
    endfunction

    function automatic t_step count_up(input t_step c);
        return (c != '1) ? c + t_step'(1) : c;
    endfunction

    function automatic logic [OUT_CNT_W-1:0] out_count(input t_step c);
        logic [32:0] w;
        begin
            w = 33'(c);
            return (w > 33'(OUT_CNT_MAX)) ? OUT_CNT_MAX : w[OUT_CNT_W-1:0];
        end
    endfunction

endpackage

### design/ddmcs_cfg_regs.sv
module ddmcs_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ddmcs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ddmcs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output ddmcs_pkg::t_cfg                     o_cfg
);

    ddmcs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drift_step      <= '0;
            r_cfg.post_drift_step <= '0;
            r_cfg.start_level     <= 31'd32768;
            r_cfg.upper_bound     <= 31'd65536;
            r_cfg.bound_collapse  <= '0;
            r_cfg.conf_upper      <= 32'sd65536;
            r_cfg.conf_lower      <= 32'sd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ddmcs_pkg::REG_DRIFT_STEP:      r_cfg.drift_step      <= i_cfg_data;
                ddmcs_pkg::REG_POST_DRIFT_STEP: r_cfg.post_drift_step <= i_cfg_data;
                ddmcs_pkg::REG_START_LEVEL:     r_cfg.start_level     <= i_cfg_data[30:0];
                ddmcs_pkg::REG_UPPER_BOUND:     r_cfg.upper_bound     <= i_cfg_data[30:0];
                ddmcs_pkg::REG_BOUND_COLLAPSE:  r_cfg.bound_collapse  <= i_cfg_data[30:0];
                ddmcs_pkg::REG_CONF_UPPER:      r_cfg.conf_upper      <= i_cfg_data;
                ddmcs_pkg::REG_CONF_LOWER:      r_cfg.conf_lower      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### design/ddmcs_trial_core.sv
module ddmcs_trial_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ddmcs_pkg::t_cfg     i_cfg,
    input  logic                i_go,
    input  logic signed [31:0]  i_noise,
    output logic                o_emit,
    output ddmcs_pkg::t_result  o_result
);

    logic                    r_post;
    logic signed [31:0]      r_ev;
    logic signed [31:0]      r_anchor;
    ddmcs_pkg::t_step        r_cnt1;
    ddmcs_pkg::t_step        r_cnt2;
    logic [30:0]             r_coll;
    logic [30:0]             r_up_sh;
    logic [30:0]             r_low_sh;
    logic                    r_chose_up;
    logic                    r_correct;

    logic                    n_post;
    logic signed [31:0]      n_ev;
    logic signed [31:0]      n_anchor;
    ddmcs_pkg::t_step        n_cnt1;
    ddmcs_pkg::t_step        n_cnt2;
    logic [30:0]             n_coll;
    logic [30:0]             n_up_sh;
    logic [30:0]             n_low_sh;
    logic                    n_chose_up;
    logic                    n_correct;

    // decision phase
    logic signed [31:0]      d_base;
    logic signed [31:0]      d_ev;
    logic signed [32:0]      d_upper;
    logic signed [31:0]      d_lower;
    logic                    d_hit_up;
    logic                    d_hit_low;
    logic                    conf_closed;

    // post-decision phase
    logic signed [31:0]      p_ev;
    logic signed [33:0]      p_hi;
    logic signed [33:0]      p_lo;
    logic signed [33:0]      p_up_sh;
    logic signed [33:0]      p_low_sh;
    logic                    p_hit_hi;
    logic                    p_hit_lo;

    always_comb begin
        d_base   = (r_cnt1 == '0) ? $signed({1'b0, i_cfg.start_level}) : r_ev;
        n_coll   = ddmcs_pkg::sat_add31(r_coll, i_cfg.bound_collapse);
        d_ev     = ddmcs_pkg::sat32(34'(d_base) + 34'(i_cfg.drift_step) + 34'(i_noise));
        d_upper  = $signed({2'b00, i_cfg.upper_bound}) - $signed({2'b00, n_coll});
        d_lower  = $signed({1'b0, n_coll});
        // upper bound wins when both are reached
        d_hit_up  = 33'(d_ev) >= d_upper;
        d_hit_low = d_ev <= d_lower;
        conf_closed = (i_cfg.conf_upper <= 32'sd0) || (i_cfg.conf_lower <= 32'sd0);

        n_up_sh  = ddmcs_pkg::sat_add31(r_up_sh, 31'(ddmcs_pkg::CONF_SLOPE_UP_STEP));
        n_low_sh = ddmcs_pkg::sat_add31(r_low_sh, 31'(ddmcs_pkg::CONF_SLOPE_LOW_STEP));
        p_up_sh  = $signed({3'b000, n_up_sh});
        p_low_sh = $signed({3'b000, n_low_sh});
        p_ev     = ddmcs_pkg::sat32(34'(r_ev) + 34'(i_cfg.post_drift_step) + 34'(i_noise));
        if (r_chose_up) begin
            p_hi = 34'(r_anchor) + 34'(i_cfg.conf_upper) - p_up_sh;
            p_lo = 34'(r_anchor) - 34'(i_cfg.conf_lower) + p_low_sh;
        end else begin
            p_hi = 34'(r_anchor) + 34'(i_cfg.conf_lower) - p_low_sh;
            p_lo = 34'(r_anchor) - 34'(i_cfg.conf_upper) + p_up_sh;
        end
        p_hit_hi = 34'(p_ev) >= p_hi;
        p_hit_lo = 34'(p_ev) <= p_lo;

        n_post     = r_post;
        n_ev       = r_ev;
        n_anchor   = r_anchor;
        n_cnt1     = r_cnt1;
        n_cnt2     = r_cnt2;
        n_chose_up = r_chose_up;
        n_correct  = r_correct;
        o_emit     = 1'b0;
        o_result.high_confidence = 1'b0;
        o_result.final_evidence  = r_anchor;

        if (!r_post) begin
            n_cnt1 = ddmcs_pkg::count_up(r_cnt1);
            n_ev   = d_ev;
            if (d_hit_up || d_hit_low) begin
                n_chose_up = d_hit_up;
                n_correct  = d_hit_up ? !i_cfg.drift_step[31] : i_cfg.drift_step[31];
                n_ev       = d_hit_up ? d_upper[31:0] : d_lower;
                n_anchor   = n_ev;
                n_post     = !conf_closed;
                o_emit     = conf_closed;
                o_result.final_evidence = n_ev;
            end
        end else begin
            n_cnt2 = ddmcs_pkg::count_up(r_cnt2);
            n_ev   = p_ev;
            o_result.final_evidence = p_ev;
            if (p_hit_hi || p_hit_lo) begin
                o_emit = 1'b1;
                o_result.high_confidence = p_hit_hi ? r_chose_up : !r_chose_up;
            end
        end

        o_result.decision_steps    = ddmcs_pkg::out_count(n_cnt1);
        o_result.choice_upper      = n_chose_up;
        o_result.correct           = n_correct;
        o_result.decision_evidence = n_anchor;
        o_result.confidence_steps  = ddmcs_pkg::out_count(n_cnt2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_post     <= 1'b0;
            r_anchor   <= '0;
            r_cnt1     <= '0;
            r_cnt2     <= '0;
            r_coll     <= '0;
            r_up_sh    <= '0;
            r_low_sh   <= '0;
            r_chose_up <= 1'b0;
            r_correct  <= 1'b0;
        end else if (i_go) begin
            r_anchor   <= n_anchor;
            r_chose_up <= n_chose_up;
            r_correct  <= n_correct;
            if (o_emit) begin
                // trial done: next request starts a new trial
                r_post   <= 1'b0;
                r_cnt1   <= '0;
                r_cnt2   <= '0;
                r_coll   <= '0;
                r_up_sh  <= '0;
                r_low_sh <= '0;
            end else begin
                r_post <= n_post;
                r_cnt1 <= n_cnt1;
                r_cnt2 <= n_cnt2;
                if (!r_post) begin
                    r_coll <= n_coll;
                end else begin
                    r_up_sh  <= n_up_sh;
                    r_low_sh <= n_low_sh;
                end
            end
        end
    end

    // evidence is reloaded from start_level at each trial's first step
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_ev <= n_ev;
        end
    end

endmodule

### design/ddm_two_stage_confidence_step.sv
// Two-stage drift-diffusion trial engine with collapsing decision bounds and
// post-decision confidence bounds.
// Input channel: one request per time step, carrying noise_step (Q16.16).
// Output channel: one result per finished trial (decision and confidence data).
// Configuration: write i_cfg_data to register i_cfg_index while i_cfg_we is
// high; only while no request is in flight. Unknown indexes are ignored.
// Timing: a request is captured in an input register, then one step of the
// trial (a three-input saturating add and the bound compares) runs from that
// register; a step that ends the trial loads the result register. A result
// passes the input register and then the result register before it is seen.
// Throughput: one request per cycle unless a stall holds it; the single-step
// add/compare loop on the evidence register sets that figure.
// Stall: while a result waits in the output register, a captured request that
// ends a trial holds and input ready drops until the result is taken.
// Requests that do not end a trial never wait on the output.
// Reset: configuration returns to its default values, the output register
// empties and a new trial starts with the next request.
module ddm_two_stage_confidence_step (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ddmcs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ddmcs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [31:0]                  i_noise_step,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ddmcs_pkg::OUT_CNT_W-1:0]     o_decision_steps,
    output logic                                o_choice_upper,
    output logic                                o_correct,
    output logic signed [31:0]                  o_decision_evidence,
    output logic signed [31:0]                  o_final_evidence,
    output logic [ddmcs_pkg::OUT_CNT_W-1:0]     o_confidence_steps,
    output logic                                o_high_confidence
);

    ddmcs_pkg::t_cfg     cfg;
    ddmcs_pkg::t_result  core_result;
    logic                core_emit;
    logic                step_go;

    logic                r_in_valid;
    logic signed [31:0]  r_noise;
    logic                r_out_valid;
    ddmcs_pkg::t_result  r_out;

    ddmcs_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ddmcs_trial_core u_trial_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_go     (step_go),
        .i_noise  (r_noise),
        .o_emit   (core_emit),
        .o_result (core_result)
    );

    assign step_go    = r_in_valid && (!core_emit || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (step_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_noise <= i_noise_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_go && core_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go && core_emit) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_decision_steps    = r_out.decision_steps;
    assign o_choice_upper      = r_out.choice_upper;
    assign o_correct           = r_out.correct;
    assign o_decision_evidence = r_out.decision_evidence;
    assign o_final_evidence    = r_out.final_evidence;
    assign o_confidence_steps  = r_out.confidence_steps;
    assign o_high_confidence   = r_out.high_confidence;

    // a captured request is neither lost nor altered while it waits
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !step_go |=> r_in_valid && $stable(r_noise))
        else $error("captured request lost or changed");

    // a taken result with no new trial end leaves the output empty
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !(step_go && core_emit) |=> !o_out_valid)
        else $error("result repeated");

    // every trial takes at least one decision step
    a_dec_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_go && core_emit |=> o_out_valid && (o_decision_steps != '0))
        else $error("result without decision step");

endmodule

### tb/tb.sv
module tb;

    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     LONG_RUN       = 48;
    localparam int     TRIAL_ITEMS    = 185;
    localparam longint EV_MAX         = 64'sd2147483647;
    localparam longint EV_MIN         = -64'sd2147483648;
    localparam logic [31:0] DEF_START = 32'd32768;
    localparam logic [31:0] DEF_UPPER = 32'd65536;
    localparam logic [31:0] DEF_CONF  = 32'd65536;
    localparam logic [ddmcs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [ddmcs_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    logic [ddmcs_pkg::CFG_DATA_W-1:0]    i_cfg_data;
    logic                                i_in_valid;
    logic                                o_in_ready;
    logic signed [31:0]                  i_noise_step;
    logic                                o_out_valid;
    logic                                i_out_ready = 1'b0;
    logic [ddmcs_pkg::OUT_CNT_W-1:0]     o_decision_steps;
    logic                                o_choice_upper;
    logic                                o_correct;
    logic signed [31:0]                  o_decision_evidence;
    logic signed [31:0]                  o_final_evidence;
    logic [ddmcs_pkg::OUT_CNT_W-1:0]     o_confidence_steps;
    logic                                o_high_confidence;

    ddm_two_stage_confidence_step dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_noise_step        (i_noise_step),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_decision_steps    (o_decision_steps),
        .o_choice_upper      (o_choice_upper),
        .o_correct           (o_correct),
        .o_decision_evidence (o_decision_evidence),
        .o_final_evidence    (o_final_evidence),
        .o_confidence_steps  (o_confidence_steps),
        .o_high_confidence   (o_high_confidence)
    );

    always #5 i_clk = ~i_clk;

    // trial predictor state
    ddmcs_pkg::t_cfg    ddm_cfg;
    bit                 post_phase;
    logic signed [31:0] evid;
    logic signed [31:0] anchor;
    ddmcs_pkg::t_step   dec_cnt;
    ddmcs_pkg::t_step   conf_cnt;
    longint             coll_sum;
    longint             up_shift;
    longint             low_shift;
    bit                 chose_up;
    bit                 was_right;

    ddmcs_pkg::t_result pending_trials[$];
    int      mismatch_cnt = 0;
    int      stuck_cycles = 0;
    int      rx_hold = 0;
    bit      calm = 1'b0;

    function automatic logic signed [31:0] clamp_ev(input longint v);
        if (v > EV_MAX) return 32'sh7FFF_FFFF;
        if (v < EV_MIN) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic longint shift_add(input longint a, input longint b);
        longint s;
        s = a + b;
        return (s > EV_MAX) ? EV_MAX : s;
    endfunction

    function automatic ddmcs_pkg::t_step step_inc(input ddmcs_pkg::t_step c);
        return (&c) ? c : c + ddmcs_pkg::t_step'(1);
    endfunction

    function automatic logic [ddmcs_pkg::OUT_CNT_W-1:0] report_cnt(
        input ddmcs_pkg::t_step c);
        return (64'(c) > 64'(ddmcs_pkg::OUT_CNT_MAX)) ? ddmcs_pkg::OUT_CNT_MAX
                                                       : ddmcs_pkg::OUT_CNT_W'(c);
    endfunction

    function automatic void close_trial(input logic signed [31:0] fin_ev, input bit high,
                                        output ddmcs_pkg::t_result r);
        r.decision_steps    = report_cnt(dec_cnt);
        r.choice_upper      = chose_up;
        r.correct           = was_right;
        r.decision_evidence = anchor;
        r.final_evidence    = fin_ev;
        r.confidence_steps  = report_cnt(conf_cnt);
        r.high_confidence   = high;
        post_phase = 1'b0;
        evid       = {1'b0, ddm_cfg.start_level};
        dec_cnt    = '0;
        conf_cnt   = '0;
        coll_sum   = 0;
        up_shift   = 0;
        low_shift  = 0;
    endfunction

    // One time step; returns 1 when the step finishes a trial.
    function automatic bit ddm_step(input logic signed [31:0] noise,
                                    output ddmcs_pkg::t_result r);
        longint ev, hi_b, lo_b, cu, cl;
        cu = longint'($signed(ddm_cfg.conf_upper));
        cl = longint'($signed(ddm_cfg.conf_lower));
        if (!post_phase) begin
            if (dec_cnt == '0) evid = {1'b0, ddm_cfg.start_level};
            dec_cnt  = step_inc(dec_cnt);
            coll_sum = shift_add(coll_sum, longint'(ddm_cfg.bound_collapse));
            ev = clamp_ev(longint'(evid) + longint'($signed(ddm_cfg.drift_step))
                          + longint'(noise));
            hi_b = longint'(ddm_cfg.upper_bound) - coll_sum;
            lo_b = coll_sum;
            // upper bound wins when the collapsed bounds have crossed
            if (ev >= hi_b) begin
                chose_up  = 1'b1;
                was_right = ($signed(ddm_cfg.drift_step) >= 0);
                ev = hi_b;
            end else if (ev <= lo_b) begin
                chose_up  = 1'b0;
                was_right = ($signed(ddm_cfg.drift_step) < 0);
                ev = lo_b;
            end else begin
                evid = ev[31:0];
                return 1'b0;
            end
            evid   = ev[31:0];
            anchor = ev[31:0];
            if (cu <= 0 || cl <= 0) begin
                close_trial(anchor, 1'b0, r);
                return 1'b1;
            end
            post_phase = 1'b1;
            return 1'b0;
        end
        conf_cnt  = step_inc(conf_cnt);
        up_shift  = shift_add(up_shift, longint'(ddmcs_pkg::CONF_SLOPE_UP_STEP));
        low_shift = shift_add(low_shift, longint'(ddmcs_pkg::CONF_SLOPE_LOW_STEP));
        ev = clamp_ev(longint'(evid) + longint'($signed(ddm_cfg.post_drift_step))
                      + longint'(noise));
        evid = ev[31:0];
        if (chose_up) begin
            hi_b = longint'(anchor) + cu - up_shift;
            lo_b = longint'(anchor) - cl + low_shift;
            if (ev >= hi_b) begin close_trial(ev[31:0], 1'b1, r); return 1'b1; end
            if (ev <= lo_b) begin close_trial(ev[31:0], 1'b0, r); return 1'b1; end
        end else begin
            // sides swap after a lower choice
            hi_b = longint'(anchor) + cl - low_shift;
            lo_b = longint'(anchor) - cu + up_shift;
            if (ev >= hi_b) begin close_trial(ev[31:0], 1'b0, r); return 1'b1; end
            if (ev <= lo_b) begin close_trial(ev[31:0], 1'b1, r); return 1'b1; end
        end
        return 1'b0;
    endfunction

    task automatic model_reset();
        ddm_cfg.drift_step      = '0;
        ddm_cfg.post_drift_step = '0;
        ddm_cfg.start_level     = DEF_START[30:0];
        ddm_cfg.upper_bound     = DEF_UPPER[30:0];
        ddm_cfg.bound_collapse  = '0;
        ddm_cfg.conf_upper      = DEF_CONF;
        ddm_cfg.conf_lower      = DEF_CONF;
        post_phase = 1'b0;
        evid       = DEF_START;
        anchor     = '0;
        dec_cnt    = '0;
        conf_cnt   = '0;
        coll_sum   = 0;
        up_shift   = 0;
        low_shift  = 0;
        chose_up   = 1'b0;
        was_right  = 1'b0;
    endtask

    function automatic int idle_len();
        if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // result side: random stalls, none started while calm
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_out_ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            i_out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) rx_hold = idle_len();
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    always @(posedge i_clk) begin : result_check
        ddmcs_pkg::t_result got, want;
        bit bad;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.decision_steps    = o_decision_steps;
            got.choice_upper      = o_choice_upper;
            got.correct           = o_correct;
            got.decision_evidence = o_decision_evidence;
            got.final_evidence    = o_final_evidence;
            got.confidence_steps  = o_confidence_steps;
            got.high_confidence   = o_high_confidence;
            if (pending_trials.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result: steps=%0d fin=%0d", got.decision_steps,
                             $signed(got.final_evidence));
            end else begin
                want = pending_trials.pop_front();
                bad = (got.decision_steps    !== want.decision_steps)
                   || (got.choice_upper      !== want.choice_upper)
                   || (got.correct           !== want.correct)
                   || (got.decision_evidence !== want.decision_evidence)
                   || (got.final_evidence    !== want.final_evidence)
                   || (got.confidence_steps  !== want.confidence_steps)
                   || (got.high_confidence   !== want.high_confidence);
                if (bad) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("exp: dsteps=%0d up=%0b ok=%0b dev=%0d fev=%0d csteps=%0d hi=%0b",
                                 want.decision_steps, want.choice_upper, want.correct,
                                 $signed(want.decision_evidence), $signed(want.final_evidence),
                                 want.confidence_steps, want.high_confidence);
                        $display("got: dsteps=%0d up=%0b ok=%0b dev=%0d fev=%0d csteps=%0d hi=%0b",
                                 got.decision_steps, got.choice_upper, got.correct,
                                 $signed(got.decision_evidence), $signed(got.final_evidence),
                                 got.confidence_steps, got.high_confidence);
                    end
                end
            end
        end
    end

    task automatic cfg_write(input logic [ddmcs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        case (idx)
            ddmcs_pkg::REG_DRIFT_STEP:      ddm_cfg.drift_step      = data;
            ddmcs_pkg::REG_POST_DRIFT_STEP: ddm_cfg.post_drift_step = data;
            ddmcs_pkg::REG_START_LEVEL:     ddm_cfg.start_level     = data[30:0];
            ddmcs_pkg::REG_UPPER_BOUND:     ddm_cfg.upper_bound     = data[30:0];
            ddmcs_pkg::REG_BOUND_COLLAPSE:  ddm_cfg.bound_collapse  = data[30:0];
            ddmcs_pkg::REG_CONF_UPPER:      ddm_cfg.conf_upper      = data;
            ddmcs_pkg::REG_CONF_LOWER:      ddm_cfg.conf_lower      = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send_noise(input logic signed [31:0] noise);
        int gap;
        ddmcs_pkg::t_result res;
        gap = (!calm && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            @(negedge i_clk) i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_noise_step = noise;
        do @(posedge i_clk); while (!o_in_ready);
        if (ddm_step(noise, res)) pending_trials.push_back(res);
    endtask

    // drain all results and let the last request clear the pipeline
    task automatic settle();
        @(negedge i_clk) i_in_valid = 1'b0;
        while (pending_trials.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic load_defaults();
        settle();
        cfg_write(ddmcs_pkg::REG_DRIFT_STEP, '0);
        cfg_write(ddmcs_pkg::REG_POST_DRIFT_STEP, '0);
        cfg_write(ddmcs_pkg::REG_START_LEVEL, DEF_START);
        cfg_write(ddmcs_pkg::REG_UPPER_BOUND, DEF_UPPER);
        cfg_write(ddmcs_pkg::REG_BOUND_COLLAPSE, '0);
        cfg_write(ddmcs_pkg::REG_CONF_UPPER, DEF_CONF);
        cfg_write(ddmcs_pkg::REG_CONF_LOWER, DEF_CONF);
    endtask

    task automatic test_extreme_noise();
        send_noise(32'sh7FFF_FFFF);
        send_noise(32'sh8000_0000);
        send_noise(32'sh0000_0000);
        send_noise(32'sh0000_0001);
        send_noise(-32'sh1);
        send_noise(32'sh0000_8000);   // lands exactly on the upper bound
        send_noise(32'sh0001_0000);   // exactly on the high confidence bound
        send_noise(32'sh8000_0000);   // lower choice
        send_noise(32'sh8000_0000);   // high confidence on the lower side
        send_noise(32'sh8000_0000);
        send_noise(32'sh7FFF_FFFF);   // low confidence on the lower side
    endtask

    task automatic test_no_conf_region();
        settle();
        cfg_write(ddmcs_pkg::REG_CONF_UPPER, '0);
        send_noise(32'sh7FFF_FFFF);
        send_noise(32'sh8000_0000);
        settle();
        cfg_write(ddmcs_pkg::REG_CONF_UPPER, DEF_CONF);
        cfg_write(ddmcs_pkg::REG_CONF_LOWER, 32'h8000_0000);
        cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
        send_noise(32'sh7FFF_FFFF);
        load_defaults();
    endtask

    task automatic test_bound_order();
        settle();
        cfg_write(ddmcs_pkg::REG_UPPER_BOUND, 32'd1000);
        cfg_write(ddmcs_pkg::REG_BOUND_COLLAPSE, 32'd600);
        cfg_write(ddmcs_pkg::REG_START_LEVEL, 32'd500);
        send_noise(32'sh0);
        send_noise(32'sh0001_0000);
        send_noise(-32'sh1);
        send_noise(32'sh8000_0000);
        settle();
        cfg_write(ddmcs_pkg::REG_BOUND_COLLAPSE, 32'h7FFF_FFFF);
        send_noise(32'sh0);
        send_noise(32'sh8000_0000);
        load_defaults();
    endtask

    task automatic test_evidence_saturation();
        settle();
        cfg_write(ddmcs_pkg::REG_DRIFT_STEP, 32'h7FFF_FFFF);
        cfg_write(ddmcs_pkg::REG_POST_DRIFT_STEP, 32'h7FFF_FFFF);
        cfg_write(ddmcs_pkg::REG_START_LEVEL, 32'hFFFF_FFFF);   // top bit dropped
        cfg_write(ddmcs_pkg::REG_UPPER_BOUND, 32'h7FFF_FFFF);
        cfg_write(ddmcs_pkg::REG_CONF_UPPER, 32'h7FFF_FFFF);
        cfg_write(ddmcs_pkg::REG_CONF_LOWER, 32'h7FFF_FFFF);
        send_noise(32'sh7FFF_FFFF);
        send_noise(32'sh7FFF_FFFF);   // high bound out of reach, evidence pinned
        settle();
        cfg_write(ddmcs_pkg::REG_POST_DRIFT_STEP, 32'h8000_0000);
        send_noise(32'sh8000_0000);
        settle();
        cfg_write(ddmcs_pkg::REG_DRIFT_STEP, 32'h8000_0000);
        send_noise(32'sh8000_0000);
        send_noise(32'sh8000_0000);
        load_defaults();
    endtask

    // long quiet decision phase, back to back, before the bound is hit
    task automatic test_long_trial();
        settle();
        calm = 1'b1;
        repeat (LONG_RUN) send_noise(32'sh0);
        send_noise(32'sh7FFF_FFFF);
        send_noise(32'sh8000_0000);
        settle();
        calm = 1'b0;
    endtask

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'h1;
            4: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_conf(input int ub);
        if ($urandom_range(0, 7) == 0) return -int'($urandom_range(0, ub));
        return $urandom_range(1, 2 * ub);
    endfunction

    task automatic pick_trial_settings(input bit extreme, output int scale);
        int ub;
        settle();
        if (extreme) begin
            cfg_write(ddmcs_pkg::REG_DRIFT_STEP, pick_extreme());
            cfg_write(ddmcs_pkg::REG_POST_DRIFT_STEP, pick_extreme());
            cfg_write(ddmcs_pkg::REG_START_LEVEL, pick_extreme());
            cfg_write(ddmcs_pkg::REG_UPPER_BOUND, pick_extreme());
            cfg_write(ddmcs_pkg::REG_BOUND_COLLAPSE, pick_extreme());
            cfg_write(ddmcs_pkg::REG_CONF_UPPER, pick_extreme());
            cfg_write(ddmcs_pkg::REG_CONF_LOWER, pick_extreme());
            scale = 1 << $urandom_range(8, 20);
        end else begin
            ub = $urandom_range(16384, 262144);
            cfg_write(ddmcs_pkg::REG_DRIFT_STEP, int'($urandom_range(0, 8192)) - 4096);
            cfg_write(ddmcs_pkg::REG_POST_DRIFT_STEP, int'($urandom_range(0, 8192)) - 4096);
            cfg_write(ddmcs_pkg::REG_UPPER_BOUND, ub);
            cfg_write(ddmcs_pkg::REG_START_LEVEL, $urandom_range(0, ub));
            cfg_write(ddmcs_pkg::REG_BOUND_COLLAPSE,
                      ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, ub / 64));
            cfg_write(ddmcs_pkg::REG_CONF_UPPER, pick_conf(ub));
            cfg_write(ddmcs_pkg::REG_CONF_LOWER, pick_conf(ub));
            scale = ub / 4;
        end
    endtask

    function automatic logic signed [31:0] noise_sample(input int scale);
        if ($urandom_range(0, 9) == 0) return $urandom;
        return int'($urandom_range(0, 2 * scale)) - scale;
    endfunction

    task automatic test_random_trials();
        int scale;
        for (int p = 0; p < 7; p++) begin
            pick_trial_settings(p == 3 || p == 6, scale);
            calm = (p == 2);
            repeat (TRIAL_ITEMS) send_noise(noise_sample(scale));
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_noise_step = '0;
        model_reset();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        test_extreme_noise();
        test_no_conf_region();
        test_bound_order();
        test_evidence_saturation();
        test_long_trial();
        test_random_trials();

        settle();
        repeat (8) @(negedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
